// ===== sv/body_sleep_state_tracker_core_defines.svh =====
// Assertion macros for the body sleep tracker checker.
// No dependencies; included by the checker file only.
`ifndef BODY_SLEEP_STATE_TRACKER_CORE_DEFINES_SVH
`define BODY_SLEEP_STATE_TRACKER_CORE_DEFINES_SVH

// same-cycle implication
`define BSST_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsst checker: same-cycle property failed");

// next-cycle implication
`define BSST_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsst checker: next-cycle property failed");

`endif

// ===== sv/bsst_pkg.sv =====
// Shared types and constants for the body sleep tracker.
// No dependencies; imported by every RTL module.
package bsst_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DECIDE,
    ST_UPDATE,
    ST_BLEND,
    ST_DIVIDE,
    ST_FINISH
  } seq_state_t;

  localparam logic [1:0] CMD_TICK       = 2'd0;
  localparam logic [1:0] CMD_ACTIVATE   = 2'd1;
  localparam logic [1:0] CMD_DEACTIVATE = 2'd2;

  localparam logic [2:0] REG_DEACT_EN    = 3'd0;
  localparam logic [2:0] REG_LIN_THR     = 3'd1;
  localparam logic [2:0] REG_ANG_THR     = 3'd2;
  localparam logic [2:0] REG_BLEND_START = 3'd3;
  localparam logic [2:0] REG_SLEEP_END   = 3'd4;

  localparam logic [15:0] DEACTIVATED_TIME = 16'd25600;  // 100 s in Q8.8
  localparam logic [15:0] SLEEP_END_RESET  = 16'd512;    // 2 s in Q8.8
  localparam logic [8:0]  BLEND_ONE        = 9'd256;

  // squaring sequence: lin thr, lin x/y/z, ang thr, ang x/y/z
  localparam logic [3:0] STEP_LIN_THR = 4'd0;
  localparam logic [3:0] STEP_LIN_X   = 4'd1;
  localparam logic [3:0] STEP_LIN_Y   = 4'd2;
  localparam logic [3:0] STEP_LIN_Z   = 4'd3;
  localparam logic [3:0] STEP_ANG_THR = 4'd4;
  localparam logic [3:0] STEP_ANG_X   = 4'd5;
  localparam logic [3:0] STEP_ANG_Y   = 4'd6;
  localparam logic [3:0] STEP_ANG_Z   = 4'd7;
  // a square issued at one step passes the product register, then the accumulator
  localparam logic [3:0] STEP_LIN_THR_CAP = 4'd2;
  localparam logic [3:0] STEP_LIN_CMP     = 4'd5;
  localparam logic [3:0] STEP_ANG_THR_CAP = 4'd6;
  localparam logic [3:0] STEP_DRAIN       = 4'd8;

  localparam int DIV_STEPS = 8;  // quotient is below 256
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic valid;
    logic clear;
  } sq_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/body_sleep_state_tracker_core.sv =====
// Rigid body sleep tracker: request channel in, one response per request out.
// Requests (command, delta_time, linear and angular velocity) are taken on
// req_valid with req_stall low; req_stall is high while a request is in work.
// A tick squares six velocity components and both thresholds through one
// shared multiplier (eight passes), then updates the inactive time and the
// awake flag. The blend factor uses an eight-step restoring divider when the
// time lies strictly inside the ramp.
// The multiplier passes and divider steps set how long a request stays in
// work; one request is in work at a time.
// The response sits in an output register, so a new request is taken while
// a response waits; rsp_stall high holds the response unchanged and, once
// the next one is ready, holds the sequencer in its finish state.
// Reset (rst, synchronous): time 0, body awake, registers to their defaults
// (sleep enabled, thresholds 0, blend start 0, end 2 s), no response.
// Configuration is an APB-style port, registers at 4*index, always ready.
module body_sleep_state_tracker_core import bsst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         command,
  input  logic [15:0]        delta_time,
  input  logic signed [15:0] lin_vel_x,
  input  logic signed [15:0] lin_vel_y,
  input  logic signed [15:0] lin_vel_z,
  input  logic signed [15:0] ang_vel_x,
  input  logic signed [15:0] ang_vel_y,
  input  logic signed [15:0] ang_vel_z,
  // response channel
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic               is_active,
  output logic               has_energy,
  output logic [15:0]        inactive_time_out,
  output logic [8:0]         blend,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic        deact_en;
  logic [15:0] lin_thr;
  logic [15:0] ang_thr;
  logic [15:0] blend_start;
  logic [15:0] sleep_end;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      deact_en    <= 1'b1;
      lin_thr     <= '0;
      ang_thr     <= '0;
      blend_start <= '0;
      sleep_end   <= SLEEP_END_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEACT_EN:    deact_en    <= pwdata[0];
        REG_LIN_THR:     lin_thr     <= pwdata[15:0];
        REG_ANG_THR:     ang_thr     <= pwdata[15:0];
        REG_BLEND_START: blend_start <= pwdata[15:0];
        REG_SLEEP_END:   sleep_end   <= pwdata[15:0];
        default: ;  // writes past the map are dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DEACT_EN:    prdata = {31'd0, deact_en};
      REG_LIN_THR:     prdata = {16'd0, lin_thr};
      REG_ANG_THR:     prdata = {16'd0, ang_thr};
      REG_BLEND_START: prdata = {16'd0, blend_start};
      REG_SLEEP_END:   prdata = {16'd0, sleep_end};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  seq_state_t state, state_next;
  logic [3:0] step;
  logic       req_take;
  logic       out_load;

  // captured request
  logic [1:0]         cmd_q;
  logic [15:0]        dt_q;
  logic signed [15:0] vel_q [6];

  // body state
  logic [15:0] inactive_time, inactive_time_next;
  logic        active_flag, active_flag_next;

  // energy test
  sq_ctrl_t           sq_ctrl;
  logic signed [16:0] sq_operand;
  logic [31:0]        sq_acc;
  logic [31:0]        thr_sq;
  logic               lin_energy;
  logic               energy;
  logic               acc_above;

  // blend
  logic        at_or_below_start;
  logic        at_or_above_end;
  logic        div_start;
  div_stat_t   div_stat;
  logic [DIV_STEPS-1:0] div_quot;
  logic [8:0]  blend_q;

  assign req_take = req_valid & ~req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (req_take) begin
        step <= '0;
      end else if (state == ST_SQUARE) begin
        step <= step + 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (command == CMD_TICK) ? ST_SQUARE : ST_UPDATE;
        end
      end
      ST_SQUARE: begin
        if (step == STEP_DRAIN) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_BLEND;
      ST_BLEND: begin
        state_next = (at_or_below_start || at_or_above_end) ? ST_FINISH : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_stall     = 1'b1;
    sq_ctrl.valid = 1'b0;
    sq_ctrl.clear = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: req_stall = 1'b0;
      ST_SQUARE: begin
        sq_ctrl.valid = ~step[3];  // issues on steps 0..7, step 8 drains
        sq_ctrl.clear = (step == STEP_LIN_THR) || (step == STEP_LIN_X) ||
                        (step == STEP_ANG_THR) || (step == STEP_ANG_X);
      end
      ST_BLEND:  div_start = ~at_or_below_start & ~at_or_above_end;
      ST_FINISH: out_load  = ~rsp_valid | ~rsp_stall;
      default: ;
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (req_take) begin
      cmd_q    <= command;
      dt_q     <= delta_time;
      vel_q[0] <= lin_vel_x;
      vel_q[1] <= lin_vel_y;
      vel_q[2] <= lin_vel_z;
      vel_q[3] <= ang_vel_x;
      vel_q[4] <= ang_vel_y;
      vel_q[5] <= ang_vel_z;
    end
  end

  // ---------------------------------------------------------------------
  // Energy test: squares through the shared unit
  // ---------------------------------------------------------------------
  always_comb begin
    case (step)
      STEP_LIN_THR: sq_operand = $signed({1'b0, lin_thr});
      STEP_LIN_X:   sq_operand = $signed({vel_q[0][15], vel_q[0]});
      STEP_LIN_Y:   sq_operand = $signed({vel_q[1][15], vel_q[1]});
      STEP_LIN_Z:   sq_operand = $signed({vel_q[2][15], vel_q[2]});
      STEP_ANG_THR: sq_operand = $signed({1'b0, ang_thr});
      STEP_ANG_X:   sq_operand = $signed({vel_q[3][15], vel_q[3]});
      STEP_ANG_Y:   sq_operand = $signed({vel_q[4][15], vel_q[4]});
      STEP_ANG_Z:   sq_operand = $signed({vel_q[5][15], vel_q[5]});
      default:      sq_operand = '0;
    endcase
  end

  bsst_sq_acc u_sq (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (sq_ctrl),
    .operand (sq_operand),
    .acc     (sq_acc)
  );

  // one comparator, used for the linear sum and then the angular sum
  assign acc_above = sq_acc > thr_sq;

  always_ff @(posedge clk) begin
    if (req_take) begin
      energy <= 1'b0;  // only a tick reports energy
    end else if (state == ST_DECIDE) begin
      energy <= lin_energy | acc_above;
    end
    if (state == ST_SQUARE) begin
      if (step == STEP_LIN_THR_CAP || step == STEP_ANG_THR_CAP) begin
        thr_sq <= sq_acc;
      end
      if (step == STEP_LIN_CMP) begin
        lin_energy <= acc_above;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Inactive time and awake flag
  // ---------------------------------------------------------------------
  logic [16:0] time_sum;
  assign time_sum = {1'b0, inactive_time} + {1'b0, dt_q};

  always_comb begin
    inactive_time_next = inactive_time;
    active_flag_next   = active_flag;
    case (cmd_q)
      CMD_TICK: begin
        if (!deact_en) begin
          inactive_time_next = '0;
          active_flag_next   = 1'b1;
        end else begin
          if (energy) begin
            inactive_time_next = (inactive_time > dt_q) ? inactive_time - dt_q : '0;
          end else if (time_sum > {1'b0, sleep_end}) begin
            inactive_time_next = sleep_end;
          end else begin
            inactive_time_next = time_sum[15:0];
          end
          active_flag_next = inactive_time_next < sleep_end;
        end
      end
      CMD_ACTIVATE: begin
        inactive_time_next = '0;
        active_flag_next   = 1'b1;
      end
      CMD_DEACTIVATE: begin
        inactive_time_next = DEACTIVATED_TIME;
        active_flag_next   = 1'b0;
      end
      default: ;  // unused code leaves the body as it is
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inactive_time <= '0;
      active_flag   <= 1'b1;
    end else if (state == ST_UPDATE) begin
      inactive_time <= inactive_time_next;
      active_flag   <= active_flag_next;
    end
  end

  // ---------------------------------------------------------------------
  // Blend factor
  // ---------------------------------------------------------------------
  assign at_or_below_start = inactive_time <= blend_start;
  assign at_or_above_end   = inactive_time >= sleep_end;

  bsst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (sleep_end - inactive_time),
    .divisor  (sleep_end - blend_start),
    .stat     (div_stat),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (state == ST_BLEND) begin
      blend_q <= at_or_below_start ? BLEND_ONE : '0;  // start test wins
    end else if (state == ST_DIVIDE && div_stat.done) begin
      blend_q <= {1'b0, div_quot};
    end
  end

  // ---------------------------------------------------------------------
  // Response register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      is_active         <= active_flag;
      has_energy        <= energy;
      inactive_time_out <= inactive_time;
      blend             <= blend_q;
    end
  end

endmodule

// ===== sv/bsst_sq_acc.sv =====
// Shared squaring unit: one registered 17x17 signed square and an accumulator.
// Depends on bsst_pkg.
module bsst_sq_acc import bsst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  sq_ctrl_t           ctrl,
  input  logic signed [16:0] operand,
  output logic [31:0]        acc
);

  logic signed [33:0] sq_full;
  logic [31:0]        prod;
  logic               prod_valid;
  logic               prod_clear;

  assign sq_full = operand * operand;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      prod_clear <= 1'b0;
    end else begin
      prod_valid <= ctrl.valid;
      prod_clear <= ctrl.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.valid) begin
      prod <= sq_full[31:0];  // square never exceeds 32 bits
    end
    if (prod_valid) begin
      acc <= prod_clear ? prod : acc + prod;
    end
  end

endmodule

// ===== sv/bsst_div.sv =====
// Restoring divider, one quotient bit a cycle, for the blend ramp.
// Depends on bsst_pkg. Requires rem_init < divisor.
module bsst_div import bsst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] rem_init,
  input  logic [15:0] divisor,
  output div_stat_t   stat,
  output logic [DIV_STEPS-1:0] quot
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic [15:0]          rem;
  logic [15:0]          dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [16:0]          shifted;
  logic [16:0]          diff;
  logic                 fits;

  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rem_init;
      dvs  <= divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? diff[15:0] : shifted[15:0];
      quot <= {quot[DIV_STEPS-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== sv/bsst_checker.sv =====
// Port-level checker for the body sleep tracker, bound to the top level.
// Depends on body_sleep_state_tracker_core_defines.svh.
`include "body_sleep_state_tracker_core_defines.svh"

module bsst_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic        is_active,
  input logic        has_energy,
  input logic [15:0] inactive_time_out,
  input logic [8:0]  blend
);

  logic req_take;
  assign req_take = req_valid & ~req_stall;

  // a held response keeps its payload
  `BSST_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall,
    rsp_valid && $stable(blend) && $stable(inactive_time_out) &&
    $stable(is_active) && $stable(has_energy))

  // blend never exceeds one
  `BSST_ASSERT_NOW(a_blend_range, clk, rst, rsp_valid, blend <= 9'd256)

  // one request in work at a time
  `BSST_ASSERT_NXT(a_busy_after_take, clk, rst, req_take, req_stall)

  // a response never appears the cycle after a request is taken
  `BSST_ASSERT_NOW(a_min_latency, clk, rst, $rose(rsp_valid),
    !$past(req_take))

endmodule

bind body_sleep_state_tracker_core bsst_checker u_bsst_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req_valid),
  .req_stall         (req_stall),
  .rsp_valid         (rsp_valid),
  .rsp_stall         (rsp_stall),
  .is_active         (is_active),
  .has_energy        (has_energy),
  .inactive_time_out (inactive_time_out),
  .blend             (blend)
);
